// ===== src/glr_pkg.sv =====
package glr_pkg;

    // Default sizes of the page line and the font store.
    localparam int PAGE_WIDTH_DEF = 128;
    localparam int FONT_WORDS_DEF = 512;

    // Control codes are moved up by this much before the glyph lookup.
    localparam logic [6:0] CTRL_LIMIT = 7'd32;
    localparam logic [6:0] CTRL_SHIFT = 7'd22;

    // The first glyph in the font store belongs to this code.
    localparam int GLYPH_BASE_CODE = 24;

    // Number of font words and glyph bits per character.
    localparam int FONT_WORDS_PER_GLYPH = 4;
    localparam int GLYPH_BITS           = 56;

    // Operation codes carried in the mode field.
    typedef enum logic [1:0] {
        MODE_CHAR  = 2'd0,
        MODE_FONT  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // One input beat.
    typedef struct packed {
        mode_t              mode;
        logic [6:0]         char_code;
        logic signed [3:0]  row_offset;
        logic               cursor;
        logic [8:0]         font_address;
        logic [13:0]        font_word;
        logic [6:0]         start_column;
    } in_beat_t;

    // One result beat.
    typedef struct packed {
        logic [6:0] column;
        logic [7:0] column_byte;
        logic       last;
    } out_beat_t;

    // Glyph width in columns for an adjusted character code.
    function automatic logic [3:0] glyph_width(input logic [6:0] c);
        logic [3:0] w;
        begin
            // Narrow glyphs: space, i, l and the open parenthesis.
            if (c == 7'h20 || c == 7'h69 || c == 7'h6c || c == 7'h28) begin
                w = 4'd5;
            // j and H.
            end else if (c == 7'h6a || c == 7'h48) begin
                w = 4'd6;
            // Wide glyphs: M, W, m and w.
            end else if (c == 7'h4d || c == 7'h57 || c == 7'h6d || c == 7'h77) begin
                w = 4'd9;
            end else begin
                w = 4'd7;
            end
            return w;
        end
    endfunction

    // Optional inversion followed by the vertical shift of one column.
    function automatic logic [7:0] column_shape(input logic [7:0] b,
                                                input logic inv,
                                                input logic signed [3:0] ofs);
        logic [7:0] v;
        logic [3:0] mag;
        begin
            v   = inv ? ~b : b;
            mag = ofs[3] ? 4'(-ofs) : 4'(ofs);
            return ofs[3] ? (v >> mag) : (v << mag);
        end
    endfunction

endpackage

// ===== src/glr_ram.sv =====
module glr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/glyph_column_renderer_top.sv =====
// Renders one character of a proportional eight-row font into one page line of an
// LCD frame buffer and reports every merged column as a result beat. A render beat
// (mode 0) keeps the block busy through the add or subtract passes of the shared
// address wrap unit, the fetch of four font words through the single read port of
// the font memory, and then, for each of the W columns of the glyph (W is the glyph
// width, 5 to 9 columns), a page memory read followed by the merge and write-back;
// a column waits if the previous result beat has not been taken. A font load
// (mode 1) passes through the same wrap unit before its write; a page clear (mode 2)
// and the unused mode leave the block idle. A character that would run past the
// page end is dropped and gives no beats. The page buffer clears at reset and on
// mode 2 at once through per-column valid bits; the font memory holds no defined
// content until it is loaded.
module glyph_column_renderer_top #(
    parameter int PAGE_WIDTH = glr_pkg::PAGE_WIDTH_DEF,
    parameter int FONT_WORDS = glr_pkg::FONT_WORDS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  glr_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output glr_pkg::out_beat_t m_data
);

    import glr_pkg::*;

    localparam int PA_W  = $clog2(PAGE_WIDTH);
    localparam int FA_W  = $clog2(FONT_WORDS);
    localparam int RED_W = ((FA_W > 9) ? FA_W : 9) + 2;
    localparam logic signed [RED_W-1:0] FW_S    = RED_W'(FONT_WORDS);
    localparam logic signed [RED_W-1:0] FW_LAST = RED_W'(FONT_WORDS - 1);
    localparam logic [8:0]              PW_LIM  = 9'(PAGE_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_FETCH,
        ST_COL_RD,
        ST_COL_WR
    } state_t;

    state_t                    state_reg, state_next;
    logic signed [RED_W-1:0]   red_reg, red_next;
    logic                      wr_reg, wr_next;
    logic [13:0]               word_reg, word_next;
    logic [2:0]                fetch_reg, fetch_next;
    logic [GLYPH_BITS-1:0]     glyph_reg, glyph_next;
    logic [3:0]                cnt_reg, cnt_next;
    logic                      inv_reg, inv_next;
    logic signed [3:0]         ofs_reg, ofs_next;
    logic [7:0]                col_reg, col_next;
    logic [PAGE_WIDTH-1:0]     valid_reg, valid_next;
    logic                      m_valid_reg, m_valid_next;
    out_beat_t                 m_data_reg, m_data_next;

    logic [6:0]                code_adj;
    logic [3:0]                wid;
    logic                      fits;
    logic signed [RED_W-1:0]   base;
    logic signed [RED_W-1:0]   red_sum;
    logic                      red_in_range;
    logic                      font_we;
    logic [13:0]               font_rdata;
    logic                      page_we;
    logic [7:0]                page_rdata;
    logic [PA_W-1:0]           page_addr;
    logic [7:0]                merged;

    // Character code adjustment, glyph width and the page end test.
    assign code_adj = (s_data.char_code < CTRL_LIMIT) ? (s_data.char_code + CTRL_SHIFT)
                                                       : s_data.char_code;
    assign wid      = glyph_width(code_adj);
    assign fits     = ({1'b0, col_reg} + 9'(wid)) <= PW_LIM;
    assign base     = ($signed({{(RED_W-7){1'b0}}, code_adj}) - RED_W'(GLYPH_BASE_CODE))
                      <<< 2;

    // Shared wrap unit: one add or subtract of the store size per cycle.
    assign red_sum      = red_reg + (red_reg[RED_W-1] ? FW_S : -FW_S);
    assign red_in_range = !red_reg[RED_W-1] && (red_reg < FW_S);

    // Merge of the current column with the page buffer byte.
    assign page_addr = col_reg[PA_W-1:0];
    assign merged    = (valid_reg[page_addr] ? page_rdata : 8'h00)
                       | column_shape(glyph_reg[GLYPH_BITS-1 -: 8], inv_reg, ofs_reg);

    glr_ram #(
        .WIDTH (14),
        .DEPTH (FONT_WORDS)
    ) u_font_ram (
        .aclk  (aclk),
        .we    (font_we),
        .waddr (red_reg[FA_W-1:0]),
        .wdata (word_reg),
        .raddr (red_reg[FA_W-1:0]),
        .rdata (font_rdata)
    );

    glr_ram #(
        .WIDTH (8),
        .DEPTH (PAGE_WIDTH)
    ) u_page_ram (
        .aclk  (aclk),
        .we    (page_we),
        .waddr (page_addr),
        .wdata (merged),
        .raddr (page_addr),
        .rdata (page_rdata)
    );

    // Sequencer next-state logic.
    always_comb begin
        state_next   = state_reg;
        red_next     = red_reg;
        wr_next      = wr_reg;
        word_next    = word_reg;
        fetch_next   = fetch_reg;
        glyph_next   = glyph_reg;
        cnt_next     = cnt_reg;
        inv_next     = inv_reg;
        ofs_next     = ofs_reg;
        col_next     = col_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        font_we      = 1'b0;
        page_we      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.mode)
                        MODE_CHAR: begin
                            if (fits) begin
                                red_next   = base;
                                wr_next    = 1'b0;
                                cnt_next   = wid;
                                inv_next   = s_data.cursor;
                                ofs_next   = s_data.row_offset;
                                state_next = ST_REDUCE;
                            end
                        end
                        MODE_FONT: begin
                            red_next   = RED_W'(s_data.font_address);
                            wr_next    = 1'b1;
                            word_next  = s_data.font_word;
                            state_next = ST_REDUCE;
                        end
                        MODE_CLEAR: begin
                            valid_next = '0;
                            col_next   = {1'b0, s_data.start_column};
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_REDUCE: begin
                // Wrap the address into the store, then write or start fetching.
                if (!red_in_range) begin
                    red_next = red_sum;
                end else if (wr_reg) begin
                    font_we    = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    fetch_next = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // Read four words in turn and shift each into the glyph.
                if (fetch_reg != 3'd0) begin
                    glyph_next = {glyph_reg[GLYPH_BITS-15:0], font_rdata};
                end
                if (fetch_reg == 3'(FONT_WORDS_PER_GLYPH)) begin
                    state_next = ST_COL_RD;
                end else begin
                    red_next   = (red_reg == FW_LAST) ? '0 : (red_reg + RED_W'(1));
                    fetch_next = fetch_reg + 3'd1;
                end
            end
            ST_COL_RD: begin
                state_next = ST_COL_WR;
            end
            ST_COL_WR: begin
                // Merge, write back and emit once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    page_we               = 1'b1;
                    valid_next[page_addr] = 1'b1;
                    m_valid_next          = 1'b1;
                    m_data_next.column      = col_reg[6:0];
                    m_data_next.column_byte = merged;
                    m_data_next.last        = (cnt_reg == 4'd1);
                    col_next   = col_reg + 8'd1;
                    cnt_next   = cnt_reg - 4'd1;
                    glyph_next = {glyph_reg[GLYPH_BITS-9:0], 8'h00};
                    state_next = (cnt_reg == 4'd1) ? ST_IDLE : ST_COL_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
        red_reg    <= red_next;
        wr_reg     <= wr_next;
        word_reg   <= word_next;
        fetch_reg  <= fetch_next;
        glyph_reg  <= glyph_next;
        cnt_reg    <= cnt_next;
        inv_reg    <= inv_next;
        ofs_reg    <= ofs_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/glr_checker.sv =====
module glr_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input glr_pkg::in_beat_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input glr_pkg::out_beat_t m_data
);

    import glr_pkg::*;

    // A result beat that is not taken stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // No result beat can appear in the cycle right after an input beat.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared one cycle after an input beat");

    // After a page clear the block is ready again in the next cycle.
    a_clear_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.mode == MODE_CLEAR) |=> s_ready)
        else $error("block busy after a page clear");

    // While a character still has columns to go the block takes no input.
    a_busy_mid_char: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && !m_data.last |-> !s_ready)
        else $error("input taken in the middle of a character");

endmodule

bind glyph_column_renderer_top glr_checker u_glr_checker (.*);

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import glr_pkg::*;

    localparam int PAGE_COLS    = 128;
    localparam int STORE_WORDS  = 512;
    localparam int RANDOM_BEATS = 384;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIRECTED_ROWS = 26;

    // Hand-computed column run for a directed row: count columns from col,
    // glyph columns carry body, the two blank columns of a wide glyph carry tail.
    typedef struct packed {
        logic       typed;
        logic [3:0] count;
        logic [6:0] col;
        logic [7:0] body;
        logic [7:0] tail;
    } known_cols_t;

    typedef struct packed {
        in_beat_t    beat;
        known_cols_t known;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    glyph_column_renderer_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Shadow copy of the block's state.
    logic [13:0] font_image   [STORE_WORDS];
    bit          glyph_written[STORE_WORDS];
    logic [7:0]  page_image   [PAGE_COLS];
    int          run_column;

    out_beat_t   pending_cols[$];
    out_beat_t   fresh_cols[$];
    known_cols_t cur_known;

    int taken_count;
    int beats_sent;
    int burst_left;
    int mismatches;
    int cycle_count;

    stim_row_t plan [DIRECTED_ROWS];

    always #5 aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // Control codes fold up onto the glyphs above them.
    function automatic logic [6:0] fold_code(input logic [6:0] raw);
        return (raw < CTRL_LIMIT) ? raw + CTRL_SHIFT : raw;
    endfunction

    // Font store address of word k of a folded code, wrapped to the store size.
    function automatic int word_addr(input logic [6:0] code, input int k);
        int a;
        a = ((int'(code) - 24) * 4 + k) % STORE_WORDS;
        if (a < 0) begin
            a += STORE_WORDS;
        end
        return a;
    endfunction

    function automatic int glyph_span(input logic [6:0] code);
        case (code)
            7'h20, 7'h69, 7'h6c, 7'h28: return 5;  // space, i, l, (
            7'h6a, 7'h48:               return 6;  // j, H
            7'h4d, 7'h57, 7'h6d, 7'h77: return 9;  // M, W, m, w
            default:                    return 7;
        endcase
    endfunction

    function automatic bit glyph_ready(input logic [6:0] raw);
        bit ok;
        ok = 1'b1;
        for (int k = 0; k < 4; k++) begin
            ok &= glyph_written[word_addr(fold_code(raw), k)];
        end
        return ok;
    endfunction

    function automatic stim_row_t row(input mode_t m, input int code, input int ofs,
                                      input bit cur, input int addr, input int word,
                                      input int start, input bit typed, input int cnt,
                                      input int col, input int body, input int tail);
        stim_row_t r;
        r.beat.mode         = m;
        r.beat.char_code    = code[6:0];
        r.beat.row_offset   = ofs[3:0];
        r.beat.cursor       = cur;
        r.beat.font_address = addr[8:0];
        r.beat.font_word    = word[13:0];
        r.beat.start_column = start[6:0];
        r.known.typed       = typed;
        r.known.count       = cnt[3:0];
        r.known.col         = col[6:0];
        r.known.body        = body[7:0];
        r.known.tail        = tail[7:0];
        return r;
    endfunction

    // Renders one character into the shadow page and collects its column beats.
    task automatic render_glyph(input in_beat_t b);
        logic [6:0]  code;
        logic [55:0] glyph;
        logic [7:0]  v;
        int          span;
        int          shift;
        out_beat_t   r;
        fresh_cols.delete();
        code = fold_code(b.char_code);
        span = glyph_span(code);
        if (run_column + span > PAGE_COLS) begin
            return;
        end
        // The four 14-bit words form one 56-bit stream of seven column bytes.
        glyph = '0;
        for (int k = 0; k < 4; k++) begin
            glyph = {glyph[41:0], font_image[word_addr(code, k)]};
        end
        shift = int'(b.row_offset);
        for (int i = 0; i < span; i++) begin
            v = (i < 7) ? glyph[55 - 8 * i -: 8] : 8'h00;
            if (b.cursor) begin
                v = ~v;
            end
            if (shift < 0) begin
                v = v >> (-shift);
            end else begin
                v = v << shift;
            end
            page_image[run_column] = page_image[run_column] | v;
            r.column      = run_column[6:0];
            r.column_byte = page_image[run_column];
            r.last        = (i == span - 1);
            fresh_cols.push_back(r);
            run_column++;
        end
    endtask

    // Applies one accepted input beat to the shadow state and queues its results.
    task automatic absorb_beat(input in_beat_t b, input known_cols_t k);
        out_beat_t r;
        taken_count++;
        case (b.mode)
            MODE_FONT: begin
                font_image[b.font_address]    = b.font_word;
                glyph_written[b.font_address] = 1'b1;
            end
            MODE_CLEAR: begin
                foreach (page_image[j]) page_image[j] = 8'h00;
                run_column = int'(b.start_column);
            end
            MODE_CHAR: begin
                render_glyph(b);
                if (k.typed) begin
                    for (int i = 0; i < k.count; i++) begin
                        r.column      = k.col + i[6:0];
                        r.column_byte = (i < 7) ? k.body : k.tail;
                        r.last        = (i == k.count - 1);
                        pending_cols.push_back(r);
                    end
                end else begin
                    foreach (fresh_cols[i]) pending_cols.push_back(fresh_cols[i]);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic compare_column(input out_beat_t got);
        out_beat_t want;
        if (pending_cols.size() == 0) begin
            if (mismatches < 10) begin
                $display("unexpected beat: col %0d byte %02h last %0b",
                         got.column, got.column_byte, got.last);
            end
            mismatches++;
        end else begin
            want = pending_cols.pop_front();
            if (got.column !== want.column || got.column_byte !== want.column_byte ||
                got.last !== want.last) begin
                if (mismatches < 10) begin
                    $display({"mismatch: expected col %0d byte %02h last %0b, ",
                              "got col %0d byte %02h last %0b"},
                             want.column, want.column_byte, want.last,
                             got.column, got.column_byte, got.last);
                end
                mismatches++;
            end
        end
    endtask

    // Both channels are sampled at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                absorb_beat(s_data, cur_known);
            end
            if (m_valid && m_ready) begin
                compare_column(m_data);
            end
        end
    end

    // Receiver: stall pattern picked afresh at random intervals.
    initial begin
        int style;
        wait (aresetn);
        forever begin
            style = $urandom_range(0, 3);
            repeat ($urandom_range(20, 80)) begin
                @(negedge aclk);
                case (style)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 7) != 0);
                    default: m_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout with %0d results outstanding", pending_cols.size());
        $display("[glyph_column_renderer_top] ERROR");
        $finish;
    end

    // Sender: one beat, held until accepted, then a gap at the end of a burst.
    task automatic send_beat(input in_beat_t b, input known_cols_t k);
        int target;
        int gap;
        s_data    <= b;
        s_valid   <= 1'b1;
        cur_known <= k;
        target = taken_count + 1;
        do @(negedge aclk); while (taken_count < target);
        beats_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                               : $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    function automatic in_beat_t noise_beat(input mode_t m);
        logic [63:0] r;
        in_beat_t    b;
        r = {$urandom, $urandom};
        b = r[$bits(in_beat_t)-1:0];
        b.mode = m;
        return b;
    endfunction

    function automatic logic [13:0] noise_word();
        case ($urandom_range(0, 5))
            0:       return 14'h0000;
            1:       return 14'h3fff;
            default: return 14'($urandom_range(0, 16383));
        endcase
    endfunction

    task automatic load_glyph(input logic [6:0] raw);
        in_beat_t b;
        for (int k = 0; k < 4; k++) begin
            b = noise_beat(MODE_FONT);
            b.font_address = 9'(word_addr(fold_code(raw), k));
            b.font_word    = noise_word();
            send_beat(b, '0);
        end
    endtask

    task automatic send_clear();
        in_beat_t b;
        int       pick;
        b = noise_beat(MODE_CLEAR);
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            b.start_column = 7'($urandom_range(0, 60));
        end else if (pick < 19) begin
            b.start_column = 7'($urandom_range(61, 127));
        end else begin
            b.start_column = 7'($urandom_range(120, 127));
        end
        send_beat(b, '0);
    endtask

    // Renders only characters whose four font words are known to be loaded.
    task automatic render_random();
        logic [6:0] raw;
        in_beat_t   b;
        int         tries;
        if (run_column > 110 && $urandom_range(0, 3) != 0) begin
            send_clear();
        end
        raw   = 7'($urandom_range(0, 127));
        tries = 0;
        while (!glyph_ready(raw) && tries < 24) begin
            raw = 7'($urandom_range(0, 127));
            tries++;
        end
        if (!glyph_ready(raw)) begin
            load_glyph(raw);
        end
        b = noise_beat(MODE_CHAR);
        b.char_code = raw;
        send_beat(b, '0);
    endtask

    initial begin
        int       pick;
        in_beat_t b;

        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        cur_known   = '0;
        run_column  = 0;
        taken_count = 0;
        beats_sent  = 0;
        mismatches  = 0;
        cycle_count = 0;
        burst_left  = $urandom_range(1, 16);
        foreach (page_image[j]) page_image[j] = 8'h00;
        foreach (glyph_written[j]) glyph_written[j] = 1'b0;
        foreach (font_image[j]) font_image[j] = 14'h0000;

        // Directed rows: all-ones M glyph at the shift extremes, the folded
        // control codes whose words sit at the top of the store, page end drops
        // and the unused mode.
        plan[0]  = row(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        plan[1]  = row(MODE_FONT, 0, 0, 0, 212, 'h3fff, 0, 1, 0, 0, 0, 0);
        plan[2]  = row(MODE_FONT, 0, 0, 0, 213, 'h3fff, 0, 1, 0, 0, 0, 0);
        plan[3]  = row(MODE_FONT, 0, 0, 0, 214, 'h3fff, 0, 1, 0, 0, 0, 0);
        plan[4]  = row(MODE_FONT, 0, 0, 0, 215, 'h3fff, 0, 1, 0, 0, 0, 0);
        plan[5]  = row(MODE_CHAR, 'h4d, 0, 0, 0, 0, 0, 1, 9, 0, 'hff, 'h00);
        plan[6]  = row(MODE_CHAR, 'h4d, -8, 0, 0, 0, 0, 1, 9, 9, 'h00, 'h00);
        plan[7]  = row(MODE_CHAR, 'h4d, 7, 1, 0, 0, 0, 1, 9, 18, 'h00, 'h80);
        plan[8]  = row(MODE_CHAR, 'h4d, -7, 1, 0, 0, 0, 1, 9, 27, 'h00, 'h01);
        plan[9]  = row(MODE_FONT, 127, -1, 1, 504, 0, 127, 1, 0, 0, 0, 0);
        plan[10] = row(MODE_FONT, 127, -1, 1, 505, 0, 127, 1, 0, 0, 0, 0);
        plan[11] = row(MODE_FONT, 127, -1, 1, 506, 0, 127, 1, 0, 0, 0, 0);
        plan[12] = row(MODE_FONT, 127, -1, 1, 507, 0, 127, 1, 0, 0, 0, 0);
        plan[13] = row(MODE_CHAR, 0, 0, 1, 0, 0, 0, 1, 7, 36, 'hff, 'h00);
        plan[14] = row(MODE_FONT, 0, 0, 0, 508, 'h2a55, 0, 1, 0, 0, 0, 0);
        plan[15] = row(MODE_FONT, 0, 0, 0, 509, 'h1c3e, 0, 1, 0, 0, 0, 0);
        plan[16] = row(MODE_FONT, 0, 0, 0, 510, 'h3001, 0, 1, 0, 0, 0, 0);
        plan[17] = row(MODE_FONT, 0, 0, 0, 511, 'h0ffe, 0, 1, 0, 0, 0, 0);
        plan[18] = row(MODE_CHAR, 1, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        plan[19] = row(MODE_CLEAR, 0, 0, 0, 0, 0, 120, 1, 0, 0, 0, 0);
        plan[20] = row(MODE_CHAR, 'h4d, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        plan[21] = row(MODE_CHAR, 0, 0, 0, 0, 0, 0, 1, 7, 120, 'h00, 'h00);
        plan[22] = row(MODE_CLEAR, 0, 0, 0, 0, 0, 127, 1, 0, 0, 0, 0);
        plan[23] = row(MODE_CHAR, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        plan[24] = row(MODE_NONE, 127, -1, 1, 511, 'h3fff, 127, 1, 0, 0, 0, 0);
        plan[25] = row(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_beat(plan[i].beat, plan[i].known);
        end

        // Random part: mostly renders, with a glyph load first where one is needed,
        // plus whole-glyph loads, stray loads, clears and unused-mode beats mixed in.
        while (beats_sent < DIRECTED_ROWS + RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                load_glyph(7'($urandom_range(0, 127)));
            end else if (pick < 18) begin
                b = noise_beat(MODE_FONT);
                b.font_word = noise_word();
                send_beat(b, '0);
            end else if (pick < 25) begin
                send_clear();
            end else if (pick < 29) begin
                send_beat(noise_beat(MODE_NONE), '0);
            end else begin
                render_random();
            end
        end
        s_valid <= 1'b0;

        while (pending_cols.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);

        if (mismatches == 0 && pending_cols.size() == 0) begin
            $display("[glyph_column_renderer_top] OK");
        end else begin
            $display("[glyph_column_renderer_top] ERROR");
        end
        $finish;
    end

endmodule
